// ----- hw/rtl/vrra_pkg.sv -----
package vrra_pkg;

   localparam int RING_BYTES  = 4096;
   localparam int MAX_RECORDS = 256;

   localparam int POS_W   = 13;
   localparam int OFF_W   = 12;
   localparam int CNT_W   = 9;
   localparam int SLOT_W  = 8;
   localparam int LEN_W   = 13;
   localparam int ENT_W   = 8;
   localparam int LOOP_W  = 10;
   localparam int HADDR_W = $clog2(RING_BYTES);
   localparam int IADDR_W = $clog2(MAX_RECORDS);

   localparam logic [POS_W-1:0]  END_MARK   = '1;
   localparam logic [LOOP_W-1:0] LOOP_BOUND = LOOP_W'(2 * MAX_RECORDS + 4);
   localparam logic [POS_W-1:0]  HDR_BYTES  = POS_W'(4);
   localparam logic [POS_W-1:0]  RING_MIN   = POS_W'(16);
   localparam logic [POS_W-1:0]  RING_MAX   = POS_W'(RING_BYTES);
   localparam logic [CNT_W-1:0]  LIMIT_MAX  = CNT_W'(MAX_RECORDS);

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic CSR_RING_BYTES  = 1'b0;
   localparam logic CSR_ENTRY_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      KIND_ALLOC,
      KIND_LOOKUP,
      KIND_CLEAR,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [LEN_W-1:0] request_length;
      logic [ENT_W-1:0] entry_number;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [OFF_W-1:0] payload_offset;
      logic [LEN_W-1:0] payload_length;
      logic [CNT_W-1:0] record_count;
      logic             fault;
   } rsp_type;

   typedef struct packed {
      kind_type         kind;
      logic [LEN_W-1:0] request_length;
      logic [ENT_W-1:0] entry_number;
   } work_type;

   typedef struct packed {
      logic [POS_W-1:0] ring;
      logic [CNT_W-1:0] limit;
   } cfg_type;

endpackage

// ----- hw/rtl/vrra_ram.sv -----
module vrra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/vrra_front.sv -----
module vrra_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vrra_pkg::req_type  req_data,
   output logic               full,
   output logic               work_valid,
   output vrra_pkg::work_type work_data,
   input  logic               work_take
);

   vrra_pkg::work_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       do_push, do_pop;
   vrra_pkg::work_type classified;

   always_comb begin
      classified.request_length = req_data.request_length;
      classified.entry_number   = req_data.entry_number;
      case (req_data.cmd)
         vrra_pkg::CMD_ALLOC:  classified.kind = vrra_pkg::KIND_ALLOC;
         vrra_pkg::CMD_LOOKUP: classified.kind = vrra_pkg::KIND_LOOKUP;
         vrra_pkg::CMD_CLEAR:  classified.kind = vrra_pkg::KIND_CLEAR;
         default:              classified.kind = vrra_pkg::KIND_NONE;
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign work_valid = (count_ff != 2'd0);
   assign work_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = work_take && work_valid;

   always_comb begin
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- hw/rtl/vrra_back.sv -----
module vrra_back (
   input  logic               clock,
   input  logic               reset,
   input  vrra_pkg::cfg_type  cfg,
   input  logic               work_valid,
   input  vrra_pkg::work_type work_data,
   output logic               work_take,
   output logic               rsp_valid,
   output vrra_pkg::rsp_type  rsp_data,
   input  logic               rsp_take
);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_CHECK     = 17'h00002,
      ST_LIMIT     = 17'h00004,
      ST_WRAP      = 17'h00008,
      ST_DRAIN     = 17'h00010,
      ST_ONCE      = 17'h00020,
      ST_MARK      = 17'h00040,
      ST_ROOM_INIT = 17'h00080,
      ST_ROOM      = 17'h00100,
      ST_EV_DATA   = 17'h00200,
      ST_MOD       = 17'h00400,
      ST_FINISH    = 17'h00800,
      ST_LOOKUP    = 17'h01000,
      ST_LK_IDX    = 17'h02000,
      ST_LK_HDR    = 17'h04000,
      ST_LK_USE    = 17'h08000,
      ST_OUT       = 17'h10000
   } state_type;

   localparam int P = vrra_pkg::POS_W;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [P-1:0] head_ff, head_in, tail_ff, tail_in, wrap_ff, wrap_in;
   logic [vrra_pkg::CNT_W-1:0] held_ff, held_in;
   logic [vrra_pkg::SLOT_W-1:0] oldest_ff, oldest_in;
   logic [vrra_pkg::LOOP_W-1:0] n_ff, n_in;
   logic [vrra_pkg::CNT_W:0] mod_ff, mod_in;
   logic [P:0] need_ff, need_in;
   logic [vrra_pkg::LEN_W-1:0] req_ff, req_in;
   logic [vrra_pkg::ENT_W-1:0] ent_ff, ent_in;
   logic is_alloc_ff, is_alloc_in;
   logic bound_ff, bound_in;
   logic oob_ff, oob_in;
   logic [vrra_pkg::OFF_W-1:0] pos_ff, pos_in;
   logic r_ok_ff, r_ok_in;
   logic [vrra_pkg::OFF_W-1:0] r_off_ff, r_off_in;
   logic [vrra_pkg::LEN_W-1:0] r_len_ff, r_len_in;
   logic out_valid_ff, out_valid_in;
   vrra_pkg::rsp_type out_ff, out_in;

   logic go_evict;
   logic [P:0] tail_need;
   logic [P-1:0] hdr_val;
   logic [vrra_pkg::CNT_W-1:0] held_dec;
   logic [vrra_pkg::CNT_W-1:0] oldest_inc;

   logic                            hdr_we;
   logic [vrra_pkg::HADDR_W-1:0]    hdr_waddr, hdr_raddr;
   logic [P-1:0]                    hdr_wdata, hdr_rdata;
   logic                            idx_we;
   logic [vrra_pkg::IADDR_W-1:0]    idx_waddr, idx_raddr;
   logic [vrra_pkg::OFF_W-1:0]      idx_wdata, idx_rdata;

   vrra_ram #(.WIDTH(P), .DEPTH(vrra_pkg::RING_BYTES)) u_hdr (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_waddr),
      .wr_data (hdr_wdata),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rdata)
   );

   vrra_ram #(.WIDTH(vrra_pkg::OFF_W), .DEPTH(vrra_pkg::MAX_RECORDS)) u_idx (
      .clock   (clock),
      .wr_en   (idx_we),
      .wr_addr (idx_waddr),
      .wr_data (idx_wdata),
      .rd_addr (idx_raddr),
      .rd_data (idx_rdata)
   );

   assign tail_need  = {1'b0, tail_ff} + need_ff;
   assign hdr_val    = oob_ff ? '0 : hdr_rdata;
   assign held_dec   = held_ff - 1'b1;
   assign oldest_inc = {1'b0, oldest_ff} + 1'b1;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wrap_in      = wrap_ff;
      held_in      = held_ff;
      oldest_in    = oldest_ff;
      n_in         = n_ff;
      mod_in       = mod_ff;
      need_in      = need_ff;
      req_in       = req_ff;
      ent_in       = ent_ff;
      is_alloc_in  = is_alloc_ff;
      bound_in     = bound_ff;
      oob_in       = oob_ff;
      pos_in       = pos_ff;
      r_ok_in      = r_ok_ff;
      r_off_in     = r_off_ff;
      r_len_in     = r_len_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      out_in       = out_ff;
      work_take    = 1'b0;
      go_evict     = 1'b0;
      hdr_we       = 1'b0;
      hdr_waddr    = tail_ff[vrra_pkg::HADDR_W-1:0];
      hdr_wdata    = vrra_pkg::END_MARK;
      hdr_raddr    = head_ff[vrra_pkg::HADDR_W-1:0];
      idx_we       = 1'b0;
      idx_waddr    = mod_ff[vrra_pkg::IADDR_W-1:0];
      idx_wdata    = tail_ff[vrra_pkg::OFF_W-1:0];
      idx_raddr    = mod_ff[vrra_pkg::IADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (work_valid) begin
               work_take = 1'b1;
               req_in    = work_data.request_length;
               ent_in    = work_data.entry_number;
               bound_in  = 1'b0;
               r_ok_in   = 1'b0;
               r_off_in  = '0;
               r_len_in  = '0;
               case (work_data.kind)
                  vrra_pkg::KIND_ALLOC:  state_in = ST_CHECK;
                  vrra_pkg::KIND_LOOKUP: state_in = ST_LOOKUP;
                  vrra_pkg::KIND_CLEAR: begin
                     head_in   = '0;
                     tail_in   = '0;
                     held_in   = '0;
                     oldest_in = '0;
                     r_ok_in   = 1'b1;
                     state_in  = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_CHECK: begin
            if ({1'b0, req_ff} < {1'b0, cfg.ring} + (P+1)'(8)) begin
               need_in     = {1'b0, req_ff} + (P+1)'(8);
               n_in        = '0;
               is_alloc_in = 1'b1;
               state_in    = ST_LIMIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_LIMIT: begin
            if (held_ff >= cfg.limit) begin
               if (n_ff >= vrra_pkg::LOOP_BOUND) begin
                  bound_in = 1'b1;
                  state_in = ST_WRAP;
               end else begin
                  n_in     = n_ff + 1'b1;
                  go_evict = 1'b1;
                  ret_in   = ST_LIMIT;
               end
            end else begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (tail_need >= {1'b0, cfg.ring}) begin
               n_in     = '0;
               state_in = (head_ff > tail_ff) ? ST_DRAIN : ST_ONCE;
            end else begin
               state_in = ST_ROOM_INIT;
            end
         end
         ST_DRAIN: begin
            if (head_ff != '0 && held_ff != '0) begin
               if (n_ff >= vrra_pkg::LOOP_BOUND) begin
                  bound_in = 1'b1;
                  state_in = ST_ONCE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  go_evict = 1'b1;
                  ret_in   = ST_DRAIN;
               end
            end else begin
               state_in = ST_ONCE;
            end
         end
         ST_ONCE: begin
            if (head_ff == '0) begin
               go_evict = 1'b1;
               ret_in   = ST_MARK;
            end else begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            // The end marker tells a later eviction to jump back to offset zero.
            hdr_we   = (held_ff != '0) && !tail_ff[P-1];
            tail_in  = '0;
            state_in = ST_ROOM_INIT;
         end
         ST_ROOM_INIT: begin
            n_in    = '0;
            wrap_in = head_ff;
            mod_in  = {2'b00, oldest_ff} + {1'b0, held_ff};
            state_in = (tail_ff < head_ff) ? ST_ROOM : ST_MOD;
         end
         ST_ROOM: begin
            if (head_ff >= wrap_ff && tail_need >= {1'b0, head_ff}) begin
               if (n_ff >= vrra_pkg::LOOP_BOUND) begin
                  bound_in = 1'b1;
                  mod_in   = {2'b00, oldest_ff} + {1'b0, held_ff};
                  state_in = ST_MOD;
               end else begin
                  n_in     = n_ff + 1'b1;
                  go_evict = 1'b1;
                  ret_in   = ST_ROOM;
               end
            end else begin
               mod_in   = {2'b00, oldest_ff} + {1'b0, held_ff};
               state_in = ST_MOD;
            end
         end
         ST_EV_DATA: begin
            state_in = ret_ff;
            if (hdr_val == vrra_pkg::END_MARK) begin
               head_in = '0;
            end else begin
               head_in = head_ff + hdr_val;
               held_in = held_dec;
               if (held_dec == '0) begin
                  head_in   = '0;
                  tail_in   = '0;
                  oldest_in = '0;
               end else if (oldest_inc >= cfg.limit) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_inc[vrra_pkg::SLOT_W-1:0];
               end
            end
         end
         ST_MOD: begin
            if (mod_ff >= {1'b0, cfg.limit}) begin
               mod_in = mod_ff - {1'b0, cfg.limit};
            end else begin
               state_in = is_alloc_ff ? ST_FINISH : ST_LK_IDX;
            end
         end
         ST_FINISH: begin
            idx_we    = 1'b1;
            hdr_we    = !tail_ff[P-1];
            hdr_wdata = req_ff + vrra_pkg::HDR_BYTES;
            held_in   = held_ff + 1'b1;
            tail_in   = tail_ff + req_ff + vrra_pkg::HDR_BYTES;
            r_ok_in   = 1'b1;
            r_off_in  = tail_ff[vrra_pkg::OFF_W-1:0] + vrra_pkg::OFF_W'(4);
            r_len_in  = req_ff;
            state_in  = ST_OUT;
         end
         ST_LOOKUP: begin
            is_alloc_in = 1'b0;
            if ({1'b0, ent_ff} < held_ff) begin
               mod_in   = {2'b00, oldest_ff} + {2'b00, ent_ff};
               state_in = ST_MOD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_LK_IDX: begin
            state_in = ST_LK_HDR;
         end
         ST_LK_HDR: begin
            pos_in    = idx_rdata;
            hdr_raddr = idx_rdata;
            oob_in    = 1'b0;
            state_in  = ST_LK_USE;
         end
         ST_LK_USE: begin
            r_ok_in  = 1'b1;
            r_off_in = pos_ff + vrra_pkg::OFF_W'(4);
            if (hdr_val == vrra_pkg::END_MARK || hdr_val < vrra_pkg::HDR_BYTES) begin
               r_len_in = '0;
            end else begin
               r_len_in = hdr_val - vrra_pkg::HDR_BYTES;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in          = 1'b1;
               out_in.ok             = r_ok_ff;
               out_in.payload_offset = r_off_ff;
               out_in.payload_length = r_len_ff;
               out_in.record_count   = held_ff;
               out_in.fault          = bound_ff || (head_ff > cfg.ring);
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Shared eviction step: an empty ring makes it a no-op.
      if (go_evict) begin
         if (held_ff == '0) begin
            state_in = ret_in;
         end else begin
            oob_in   = head_ff[P-1];
            state_in = ST_EV_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         oldest_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         oldest_ff    <= oldest_in;
         out_valid_ff <= out_valid_in;
      end
      wrap_ff     <= wrap_in;
      n_ff        <= n_in;
      mod_ff      <= mod_in;
      need_ff     <= need_in;
      req_ff      <= req_in;
      ent_ff      <= ent_in;
      is_alloc_ff <= is_alloc_in;
      bound_ff    <= bound_in;
      oob_ff      <= oob_in;
      pos_ff      <= pos_in;
      r_ok_ff     <= r_ok_in;
      r_off_ff    <= r_off_in;
      r_len_ff    <= r_len_in;
      out_ff      <= out_in;
   end

endmodule

// ----- hw/rtl/variable_record_ring_allocator_core.sv -----
// Variable-length record ring allocator.
// Commands enter as items on a queue-style port: an item is taken on a clock edge where
// req_push is high and req_full is low. Allocate places a record (4-byte length header plus
// payload) in the byte ring, evicting the oldest records when the entry limit is reached or
// when the new record needs the space; lookup returns offset and size of record n counted
// from the oldest; clear empties the ring. Every item yields exactly one result item.
// Results wait on rsp_data while rsp_empty is low and leave on an edge with rsp_pop high.
// A two-entry command queue feeds the sequencer, so the producer can keep pushing while the
// sequencer works, and a one-entry result register lets the sequencer finish the next
// command while the previous result waits to be popped.
// Clear and unused commands go straight to the result register. A lookup and an allocate
// take longer for each limit subtraction in the slot modulo step; an allocate also for the
// room check when the tail sits below the head, for the wrap to offset zero, and for each
// evicted record, since each eviction needs one registered read of the header memory.
// When the consumer stalls, the sequencer holds its finished result and stops, and the
// command queue fills and raises req_full.
// Reset (synchronous, active high) empties the ring, both queues, and sets ring_bytes to
// 4096 and entry_limit to 256. The header and position memories are not cleared.
// Configuration writes use csr_valid/csr_ready (always ready) and must be made while idle.
module variable_record_ring_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  vrra_pkg::req_type             req_data,
   output logic                          req_full,
   output logic                          rsp_empty,
   output vrra_pkg::rsp_type             rsp_data,
   input  logic                          rsp_pop,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [vrra_pkg::POS_W-1:0]    csr_wdata
);

   logic [vrra_pkg::POS_W-1:0] ring_bytes_ff;
   logic [vrra_pkg::CNT_W-1:0] entry_limit_ff;
   vrra_pkg::cfg_type          cfg;
   logic                       work_valid, work_take, rsp_valid;
   vrra_pkg::work_type         work_data;

   assign csr_ready = 1'b1;

   // Registers hold the raw written values; the sequencer sees them clamped to legal ranges.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_bytes_ff  <= vrra_pkg::RING_MAX;
         entry_limit_ff <= vrra_pkg::LIMIT_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            vrra_pkg::CSR_RING_BYTES:  ring_bytes_ff  <= csr_wdata;
            vrra_pkg::CSR_ENTRY_LIMIT: entry_limit_ff <= csr_wdata[vrra_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ring_bytes_ff < vrra_pkg::RING_MIN) begin
         cfg.ring = vrra_pkg::RING_MIN;
      end else if (ring_bytes_ff > vrra_pkg::RING_MAX) begin
         cfg.ring = vrra_pkg::RING_MAX;
      end else begin
         cfg.ring = ring_bytes_ff;
      end
      if (entry_limit_ff == '0) begin
         cfg.limit = vrra_pkg::CNT_W'(1);
      end else if (entry_limit_ff > vrra_pkg::LIMIT_MAX) begin
         cfg.limit = vrra_pkg::LIMIT_MAX;
      end else begin
         cfg.limit = entry_limit_ff;
      end
   end

   vrra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .req_data   (req_data),
      .full       (req_full),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_take  (work_take)
   );

   vrra_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_take  (work_take),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_take   (rsp_pop)
   );

   assign rsp_empty = !rsp_valid;

endmodule

// ----- hw/rtl/vrra_checker.sv -----
module vrra_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input vrra_pkg::rsp_type rsp_data
);

   // Nothing is waiting right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // A refused command reports no offset and no length.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.ok) |->
      (rsp_data.payload_offset == '0 && rsp_data.payload_length == '0))
      else $error("refused result carries data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.record_count <= vrra_pkg::LIMIT_MAX))
      else $error("record count above capacity");

endmodule

bind variable_record_ring_allocator_core vrra_checker u_vrra_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_variable_record_ring_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_variable_record_ring_allocator_core;

   localparam int EVICT_BOUND = 2 * vrra_pkg::MAX_RECORDS + 4;
   localparam logic [1:0] CMD_UNUSED = 2'b11;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   vrra_pkg::req_type              req_data = '0;
   logic                           req_full;
   logic                           rsp_empty;
   vrra_pkg::rsp_type              rsp_data;
   logic                           rsp_pop = 1'b0;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic                           csr_index = vrra_pkg::CSR_RING_BYTES;
   logic [vrra_pkg::POS_W-1:0]     csr_wdata = '0;

   variable_record_ring_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Commands waiting to be offered, and replies the allocator owes us.
   vrra_pkg::req_type pending_cmds[$];
   vrra_pkg::rsp_type expected_replies[$];
   int      fail_count = 0;
   bit      quiet_tail = 1'b0;

   // Shadow of the allocator: registers, pointers and both memories.
   int               ring_reg = vrra_pkg::RING_BYTES;
   int               limit_reg = vrra_pkg::MAX_RECORDS;
   int               head_pos = 0;
   int               tail_pos = 0;
   int               held_count = 0;
   int               oldest_slot = 0;
   logic [vrra_pkg::POS_W-1:0] header_mem[vrra_pkg::RING_BYTES];
   logic [vrra_pkg::OFF_W-1:0] slot_offsets[vrra_pkg::MAX_RECORDS];

   function automatic int clamped_ring();
      if (ring_reg < 16) return 16;
      if (ring_reg > vrra_pkg::RING_BYTES) return vrra_pkg::RING_BYTES;
      return ring_reg;
   endfunction

   function automatic int clamped_limit();
      if (limit_reg < 1) return 1;
      if (limit_reg > vrra_pkg::MAX_RECORDS) return vrra_pkg::MAX_RECORDS;
      return limit_reg;
   endfunction

   function automatic int header_at(int pos);
      if (pos >= vrra_pkg::RING_BYTES) return 0;
      return int'(header_mem[pos]);
   endfunction

   task automatic empty_ring();
      head_pos = 0;
      tail_pos = 0;
      held_count = 0;
      oldest_slot = 0;
   endtask

   // Drops the oldest record; an end marker at the head just wraps the head.
   task automatic drop_oldest();
      int h;
      if (held_count == 0) return;
      h = header_at(head_pos);
      if (h == int'(vrra_pkg::END_MARK)) begin
         head_pos = 0;
         return;
      end
      head_pos = (head_pos + h) & 'h1FFF;
      held_count--;
      if (held_count == 0) begin
         empty_ring();
      end else begin
         oldest_slot++;
         if (oldest_slot >= clamped_limit()) oldest_slot = 0;
      end
   endtask

   // Applies one command to the shadow ring and returns the reply it causes.
   task automatic predict_ring_command(input vrra_pkg::req_type cmd_item,
                                       output vrra_pkg::rsp_type reply);
      int  ring, limit, req, need, n, wrap, slot, pos, h;
      bit  bound_hit;
      ring = clamped_ring();
      limit = clamped_limit();
      req = int'(cmd_item.request_length);
      bound_hit = 1'b0;
      reply = '0;
      case (cmd_item.cmd)
         vrra_pkg::CMD_ALLOC: begin
            if (req < ring + 8) begin
               need = req + 8;
               // Make room in the record count first.
               for (n = 0; held_count >= limit; n++) begin
                  if (n >= EVICT_BOUND) begin
                     bound_hit = 1'b1;
                     break;
                  end
                  drop_oldest();
               end
               // The record would cross the ring end: mark the end, restart at 0.
               if (tail_pos + need >= ring) begin
                  if (head_pos > tail_pos) begin
                     for (n = 0; head_pos != 0 && held_count != 0; n++) begin
                        if (n >= EVICT_BOUND) begin
                           bound_hit = 1'b1;
                           break;
                        end
                        drop_oldest();
                     end
                  end
                  if (head_pos == 0) drop_oldest();
                  if (held_count != 0 && tail_pos < vrra_pkg::RING_BYTES)
                     header_mem[tail_pos] = vrra_pkg::END_MARK;
                  tail_pos = 0;
               end
               // Evict the records that the new one would overlap.
               if (tail_pos < head_pos) begin
                  wrap = head_pos;
                  for (n = 0; head_pos >= wrap && tail_pos + need >= head_pos; n++) begin
                     if (n >= EVICT_BOUND) begin
                        bound_hit = 1'b1;
                        break;
                     end
                     drop_oldest();
                  end
               end
               slot = (oldest_slot + held_count) % limit;
               slot_offsets[slot] = tail_pos[vrra_pkg::OFF_W-1:0];
               held_count++;
               if (tail_pos < vrra_pkg::RING_BYTES)
                  header_mem[tail_pos] = vrra_pkg::POS_W'(req + 4);
               pos = tail_pos;
               tail_pos = (tail_pos + req + 4) & 'h1FFF;
               reply.ok = 1'b1;
               reply.payload_offset = vrra_pkg::OFF_W'(pos + 4);
               reply.payload_length = vrra_pkg::LEN_W'(req);
            end
         end
         vrra_pkg::CMD_LOOKUP: begin
            if (int'(cmd_item.entry_number) < held_count) begin
               slot = (oldest_slot + int'(cmd_item.entry_number)) % limit;
               pos = int'(slot_offsets[slot]);
               h = header_at(pos);
               reply.ok = 1'b1;
               reply.payload_offset = vrra_pkg::OFF_W'(pos + 4);
               reply.payload_length = (h == int'(vrra_pkg::END_MARK) || h < 4) ?
                                      '0 : vrra_pkg::LEN_W'(h - 4);
            end
         end
         vrra_pkg::CMD_CLEAR: begin
            empty_ring();
            reply.ok = 1'b1;
         end
         default: ;
      endcase
      reply.record_count = vrra_pkg::CNT_W'(held_count);
      reply.fault = bound_hit || head_pos > ring;
   endtask

   // Driver: offers pending items, holds an offer while the block is full,
   // and otherwise inserts idle bursts at random.
   int gap_left = 0;
   always @(posedge clock) begin
      vrra_pkg::rsp_type  reply;
      bit                 taken;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         taken = req_push && !req_full;
         if (taken) begin
            predict_ring_command(pending_cmds.pop_front(), reply);
            expected_replies.push_back(reply);
         end
         if (req_push && !taken) begin
            req_push <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 4);
            req_push <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_push <= 1'b1;
            req_data <= pending_cmds[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: pops replies with random stalls, and twice holds off for a long
   // stretch so that the command queue fills and the block raises full.
   int stall_left = 0;
   int replies_seen = 0;
   always @(posedge clock) begin
      vrra_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
               $error("reply with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
                  fail_count++;
               end
               if (rsp_data.payload_offset !== want.payload_offset) begin
                  $error("payload_offset: expected %0d, got %0d",
                         want.payload_offset, rsp_data.payload_offset);
                  fail_count++;
               end
               if (rsp_data.payload_length !== want.payload_length) begin
                  $error("payload_length: expected %0d, got %0d",
                         want.payload_length, rsp_data.payload_length);
                  fail_count++;
               end
               if (rsp_data.record_count !== want.record_count) begin
                  $error("record_count: expected %0d, got %0d",
                         want.record_count, rsp_data.record_count);
                  fail_count++;
               end
               if (rsp_data.fault !== want.fault) begin
                  $error("fault: expected %0d, got %0d", want.fault, rsp_data.fault);
                  fail_count++;
               end
            end
            if (replies_seen == 150 || replies_seen == 800) stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic vrra_pkg::req_type make_cmd(logic [1:0] op, int length, int entry);
      vrra_pkg::req_type c;
      c.cmd = op;
      c.request_length = vrra_pkg::LEN_W'(length);
      c.entry_number = vrra_pkg::ENT_W'(entry);
      return c;
   endfunction

   // Random command mix: mostly allocations and lookups near the oldest
   // records, with oversized requests, clears and the unused code as noise.
   function automatic vrra_pkg::req_type random_cmd(int ring);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return make_cmd(vrra_pkg::CMD_ALLOC, $urandom_range(0, ring / 8), 0);
      if (pick < 52) return make_cmd(vrra_pkg::CMD_ALLOC, $urandom_range(0, ring + 7), 0);
      if (pick < 55) return make_cmd(vrra_pkg::CMD_ALLOC, $urandom_range(0, 8191), 0);
      if (pick < 85) return make_cmd(vrra_pkg::CMD_LOOKUP, 0, $urandom_range(0, 15));
      if (pick < 96) return make_cmd(vrra_pkg::CMD_LOOKUP, 0, $urandom_range(0, 255));
      if (pick < 98)
         return make_cmd(vrra_pkg::CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 255));
      return make_cmd(CMD_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 255));
   endfunction

   task automatic write_csr(logic index, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= vrra_pkg::POS_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (index == vrra_pkg::CSR_RING_BYTES) ring_reg = value & 'h1FFF;
      else limit_reg = value & 'h1FF;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending_cmds.size() != 0 || expected_replies.size() != 0
                                   || req_push);
      repeat (4) @(negedge clock);
   endtask

   // Ring size and entry limit per phase, including out-of-range values that
   // the block clamps.
   int ring_plan[8]  = '{4096, 16, 100, 4096, 16, 777, 8191, 0};
   int limit_plan[8] = '{256, 1, 3, 1, 256, 17, 0, 511};

   initial begin
      int ring;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 8; ph++) begin
         // Clear the ring so that a new size or limit starts from a clean state.
         if (ph > 0) begin
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_CLEAR, 0, 0));
            wait_drained();
         end
         write_csr(vrra_pkg::CSR_RING_BYTES, ring_plan[ph]);
         write_csr(vrra_pkg::CSR_ENTRY_LIMIT, limit_plan[ph]);
         ring = clamped_ring();
         if (ph == 7) quiet_tail = 1'b1;
         if (ph == 0) begin
            // Directed items: length extremes, wrap, oversize, lookups and codes.
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 0, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 1000, 255));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 2000, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 2));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 3));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 1500, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 4096, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 4103, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 4104, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, 8191, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 255));
            pending_cmds.push_back(make_cmd(CMD_UNUSED, 8191, 255));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_CLEAR, 0, 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 0));
            for (int k = 0; k < 20; k++)
               pending_cmds.push_back(make_cmd(vrra_pkg::CMD_ALLOC, $urandom_range(0, 300), 0));
            pending_cmds.push_back(make_cmd(vrra_pkg::CMD_LOOKUP, 0, 19));
            wait_drained();
         end
         for (int k = 0; k < 165; k++) pending_cmds.push_back(random_cmd(ring));
         wait_drained();
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("** variable_record_ring_allocator_core: PASSED **");
      end else begin
         $display("** variable_record_ring_allocator_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("** variable_record_ring_allocator_core: FAILED **");
      $finish;
   end

endmodule

// ----- variable_record_ring_allocator_core.f -----
hw/rtl/vrra_pkg.sv
hw/rtl/vrra_ram.sv
hw/rtl/vrra_front.sv
hw/rtl/vrra_back.sv
hw/rtl/variable_record_ring_allocator_core.sv
hw/rtl/vrra_checker.sv
tb/tb_variable_record_ring_allocator_core.sv
